/* rtl/clru_pkg.sv */
`default_nettype none

package clru_pkg;

  typedef enum logic [2:0] {
    MODE_IMM  = 3'd0,
    MODE_ZP   = 3'd1,
    MODE_ZPI  = 3'd2,
    MODE_ABS  = 3'd3,
    MODE_ABSI = 3'd4,
    MODE_INX  = 3'd5,
    MODE_INY  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2
  } sel_t;

  typedef struct packed {
    logic  ok;
    mode_t mode;
    sel_t  dest;
    sel_t  idx;
  } op_info_t;

  localparam logic [1:0] RK_READ  = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_UNSUP = 2'd2;
  localparam logic [1:0] RK_SEQ   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        z;
    logic        n;
    logic [2:0]  cyc;
  } res_t;

endpackage

`default_nettype wire

/* rtl/clru_decode.sv */
`default_nettype none

module clru_decode (
  input  wire logic [7:0]         opcode,
  output clru_pkg::op_info_t      info
);
  import clru_pkg::*;

  localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
  localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
  localparam logic [7:0] OP_LDA_INX  = 8'hA1;
  localparam logic [7:0] OP_LDA_INY  = 8'hB1;
  localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY  = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS  = 8'hAE;
  localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
  localparam logic [7:0] OP_LDY_ABSX = 8'hBC;

  always_comb begin
    info = '{ok: 1'b1, mode: MODE_IMM, dest: SEL_A, idx: SEL_A};
    case (opcode)
      OP_LDA_IMM:  info = '{1'b1, MODE_IMM,  SEL_A, SEL_A};
      OP_LDA_ZP:   info = '{1'b1, MODE_ZP,   SEL_A, SEL_A};
      OP_LDA_ZPX:  info = '{1'b1, MODE_ZPI,  SEL_A, SEL_X};
      OP_LDA_ABS:  info = '{1'b1, MODE_ABS,  SEL_A, SEL_A};
      OP_LDA_ABSX: info = '{1'b1, MODE_ABSI, SEL_A, SEL_X};
      OP_LDA_ABSY: info = '{1'b1, MODE_ABSI, SEL_A, SEL_Y};
      OP_LDA_INX:  info = '{1'b1, MODE_INX,  SEL_A, SEL_X};
      OP_LDA_INY:  info = '{1'b1, MODE_INY,  SEL_A, SEL_Y};
      OP_LDX_IMM:  info = '{1'b1, MODE_IMM,  SEL_X, SEL_A};
      OP_LDX_ZP:   info = '{1'b1, MODE_ZP,   SEL_X, SEL_A};
      OP_LDX_ZPY:  info = '{1'b1, MODE_ZPI,  SEL_X, SEL_Y};
      OP_LDX_ABS:  info = '{1'b1, MODE_ABS,  SEL_X, SEL_A};
      OP_LDX_ABSY: info = '{1'b1, MODE_ABSI, SEL_X, SEL_Y};
      OP_LDY_IMM:  info = '{1'b1, MODE_IMM,  SEL_Y, SEL_A};
      OP_LDY_ZP:   info = '{1'b1, MODE_ZP,   SEL_Y, SEL_A};
      OP_LDY_ZPX:  info = '{1'b1, MODE_ZPI,  SEL_Y, SEL_X};
      OP_LDY_ABS:  info = '{1'b1, MODE_ABS,  SEL_Y, SEL_A};
      OP_LDY_ABSX: info = '{1'b1, MODE_ABSI, SEL_Y, SEL_X};
      default:     info = '{1'b0, MODE_IMM,  SEL_A, SEL_A};
    endcase
  end

endmodule

`default_nettype wire

/* rtl/clru_exec.sv */
`default_nettype none

module clru_exec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        item_kind,
  input  wire logic [7:0]  opcode,
  input  wire logic [15:0] operand,
  input  wire logic [7:0]  read_data,
  output clru_pkg::res_t   res
);
  import clru_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_PLO  = 4'b0100,
    PH_PHI  = 4'b1000
  } phase_t;

  function automatic logic [2:0] base_cycles(input mode_t m);
    case (m)
      MODE_IMM:  base_cycles = 3'd2;
      MODE_ZP:   base_cycles = 3'd3;
      MODE_ZPI:  base_cycles = 3'd4;
      MODE_ABS:  base_cycles = 3'd4;
      MODE_ABSI: base_cycles = 3'd4;
      MODE_INX:  base_cycles = 3'd6;
      MODE_INY:  base_cycles = 3'd5;
      default:   base_cycles = 3'd0;
    endcase
  endfunction

  phase_t      phase, phase_next;
  logic [7:0]  acc, idx_x, idx_y;
  logic        zflag, nflag;
  logic [7:0]  pending_opcode, pending_opcode_next;
  logic [7:0]  ptr, ptr_next;
  logic [7:0]  plo, plo_next;
  logic        page_crossed, page_crossed_next;

  op_info_t    dnew, dpend;
  logic [7:0]  zp, idx_val, ptr_new;
  logic [15:0] absi_sum, ptr_base, iny_sum;
  logic        load_en;
  sel_t        load_dest;
  logic [7:0]  load_val;
  logic        penalty;

  clru_decode u_dec_new  (.opcode(opcode),         .info(dnew));
  clru_decode u_dec_pend (.opcode(pending_opcode), .info(dpend));

  assign zp       = operand[7:0];
  assign idx_val  = (dnew.idx == SEL_X) ? idx_x : ((dnew.idx == SEL_Y) ? idx_y : 8'h00);
  assign absi_sum = operand + {8'h00, idx_val};
  assign ptr_new  = (dnew.mode == MODE_INX) ? zp + idx_x : zp;
  assign ptr_base = {read_data, plo};
  assign iny_sum  = ptr_base + {8'h00, idx_y};
  assign penalty  = page_crossed && (dpend.mode == MODE_ABSI || dpend.mode == MODE_INY);

  always_comb begin
    phase_next          = phase;
    pending_opcode_next = pending_opcode;
    ptr_next            = ptr;
    plo_next            = plo;
    page_crossed_next   = page_crossed;
    load_en             = 1'b0;
    load_dest           = dnew.dest;
    load_val            = zp;
    res.kind            = RK_SEQ;
    res.addr            = 16'h0000;
    res.cyc             = 3'd0;
    if (!item_kind) begin
      if (phase != PH_IDLE) begin
        res.kind = RK_SEQ;
      end else if (!dnew.ok) begin
        res.kind = RK_UNSUP;
      end else begin
        pending_opcode_next = opcode;
        page_crossed_next   = 1'b0;
        res.kind            = RK_READ;
        phase_next          = PH_DATA;
        case (dnew.mode)
          MODE_IMM: begin
            load_en    = 1'b1;
            res.kind   = RK_DONE;
            res.cyc    = base_cycles(MODE_IMM);
            phase_next = PH_IDLE;
          end
          MODE_ZP:  res.addr = {8'h00, zp};
          MODE_ZPI: res.addr = {8'h00, zp + idx_val};
          MODE_ABS: res.addr = operand;
          MODE_ABSI: begin
            res.addr          = absi_sum;
            page_crossed_next = absi_sum[15:8] != operand[15:8];
          end
          MODE_INX, MODE_INY: begin
            ptr_next   = ptr_new;
            phase_next = PH_PLO;
            res.addr   = {8'h00, ptr_new};
          end
          default: res.kind = RK_UNSUP;
        endcase
      end
    end else if (phase == PH_IDLE || !dpend.ok) begin
      res.kind = RK_SEQ;
    end else begin
      case (phase)
        PH_PLO: begin
          plo_next   = read_data;
          phase_next = PH_PHI;
          res.kind   = RK_READ;
          res.addr   = {8'h00, ptr + 8'd1};
        end
        PH_PHI: begin
          phase_next = PH_DATA;
          res.kind   = RK_READ;
          if (dpend.mode == MODE_INY) begin
            res.addr          = iny_sum;
            page_crossed_next = iny_sum[15:8] != read_data;
          end else begin
            res.addr          = ptr_base;
            page_crossed_next = 1'b0;
          end
        end
        PH_DATA: begin
          load_en    = 1'b1;
          load_dest  = dpend.dest;
          load_val   = read_data;
          phase_next = PH_IDLE;
          res.kind   = RK_DONE;
          res.cyc    = base_cycles(dpend.mode) + {2'b00, penalty};
        end
        default: res.kind = RK_SEQ;
      endcase
    end
    res.a = (load_en && load_dest == SEL_A) ? load_val : acc;
    res.x = (load_en && load_dest == SEL_X) ? load_val : idx_x;
    res.y = (load_en && load_dest == SEL_Y) ? load_val : idx_y;
    res.z = load_en ? (load_val == 8'h00) : zflag;
    res.n = load_en ? load_val[7] : nflag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      acc            <= 8'h00;
      idx_x          <= 8'h00;
      idx_y          <= 8'h00;
      zflag          <= 1'b0;
      nflag          <= 1'b0;
      pending_opcode <= 8'h00;
      ptr            <= 8'h00;
      plo            <= 8'h00;
      page_crossed   <= 1'b0;
    end else if (adv) begin
      phase          <= phase_next;
      acc            <= res.a;
      idx_x          <= res.x;
      idx_y          <= res.y;
      zflag          <= res.z;
      nflag          <= res.n;
      pending_opcode <= pending_opcode_next;
      ptr            <= ptr_next;
      plo            <= plo_next;
      page_crossed   <= page_crossed_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    adv && res.kind == RK_DONE |=> phase == PH_IDLE)
    else $error("phase not idle after a completed load");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    adv && res.kind == RK_READ |=> phase != PH_IDLE)
    else $error("phase idle after a read request");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    adv && (res.kind == RK_UNSUP || res.kind == RK_SEQ) |=>
      phase == $past(phase) && acc == $past(acc) && idx_x == $past(idx_x)
      && idx_y == $past(idx_y) && pending_opcode == $past(pending_opcode))
    else $error("rejected item changed state");

  a_busy_known: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> dpend.ok)
    else $error("pending opcode not a load");

endmodule

`default_nettype wire

/* rtl/cpu_load_register_unit.sv */
// Load unit for the 8-bit CPU loads into A, X and Y with Z and N flags.
// Input channel (in_valid / in_stall): an instruction item (item_kind 0,
// opcode and operand) or a returned memory byte (item_kind 1, read_data).
// Output channel (out_valid / out_stall): exactly one result item per
// input item, in order: a read request with read_address, a completed
// load with its cycle count, an unsupported opcode, or an item out of
// sequence. Each result carries A, X, Y and the flags after that item.
// An accepted item is held in the input register and processed from it
// combinationally; it moves to the result register when that register
// is empty or its result is taken, so a receiver stall can hold it.
// Throughput: one item per cycle while the receiver does not stall, set
// by the single pass from input register through decode and address add
// to result register. Receiver stall holds the result register; an empty
// input register still takes one more item, after which in_stall rises.
// Reset clears A, X, Y, flags and the load sequence and empties both
// registers.
`default_nettype none

module cpu_load_register_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        item_kind,
  input  wire logic [7:0]  opcode,
  input  wire logic [15:0] operand,
  input  wire logic [7:0]  read_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [15:0]      read_address,
  output logic [7:0]       reg_a,
  output logic [7:0]       reg_x,
  output logic [7:0]       reg_y,
  output logic             flag_zero,
  output logic             flag_negative,
  output logic [2:0]       cycles_used
);
  import clru_pkg::*;

  logic        hold_valid;
  logic        hold_kind;
  logic [7:0]  hold_opcode;
  logic [15:0] hold_operand;
  logic [7:0]  hold_data;
  logic        adv;
  res_t        res;
  res_t        out_res;

  assign adv      = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !adv;

  clru_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .item_kind (hold_kind),
    .opcode    (hold_opcode),
    .operand   (hold_operand),
    .read_data (hold_data),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_kind    <= item_kind;
      hold_opcode  <= opcode;
      hold_operand <= operand;
      hold_data    <= read_data;
    end
    if (adv) begin
      out_res <= res;
    end
  end

  assign result_kind   = out_res.kind;
  assign read_address  = out_res.addr;
  assign reg_a         = out_res.a;
  assign reg_x         = out_res.x;
  assign reg_y         = out_res.y;
  assign flag_zero     = out_res.z;
  assign flag_negative = out_res.n;
  assign cycles_used   = out_res.cyc;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !hold_valid |=> !out_valid)
    else $error("result register refilled from an empty input register");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    hold_valid |=> out_valid)
    else $error("held item did not reach the result register");

endmodule

`default_nettype wire

/* bench/cpu_load_register_unit_checker.sv */
`timescale 1ns / 1ps

package clru_bench_pkg;

  localparam logic ITEM_INSTR = 1'b0;
  localparam logic ITEM_DATA  = 1'b1;

  localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
  localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
  localparam logic [7:0] OP_LDA_INDX = 8'hA1;
  localparam logic [7:0] OP_LDA_INDY = 8'hB1;
  localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY  = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS  = 8'hAE;
  localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
  localparam logic [7:0] OP_LDY_ABSX = 8'hBC;

  function automatic logic [7:0] load_opcode(input int unsigned i);
    case (i)
      0:       return OP_LDA_IMM;
      1:       return OP_LDA_ZP;
      2:       return OP_LDA_ZPX;
      3:       return OP_LDA_ABS;
      4:       return OP_LDA_ABSX;
      5:       return OP_LDA_ABSY;
      6:       return OP_LDA_INDX;
      7:       return OP_LDA_INDY;
      8:       return OP_LDX_IMM;
      9:       return OP_LDX_ZP;
      10:      return OP_LDX_ZPY;
      11:      return OP_LDX_ABS;
      12:      return OP_LDX_ABSY;
      13:      return OP_LDY_IMM;
      14:      return OP_LDY_ZP;
      15:      return OP_LDY_ZPX;
      16:      return OP_LDY_ABS;
      default: return OP_LDY_ABSX;
    endcase
  endfunction

endpackage

module cpu_load_register_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        item_kind,
  input  logic [7:0]  opcode,
  input  logic [15:0] operand,
  input  logic [7:0]  read_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  result_kind,
  input  logic [15:0] read_address,
  input  logic [7:0]  reg_a,
  input  logic [7:0]  reg_x,
  input  logic [7:0]  reg_y,
  input  logic        flag_zero,
  input  logic        flag_negative,
  input  logic [2:0]  cycles_used,
  output int          fail_count,
  output int          pending
);
  import clru_pkg::*;
  import clru_bench_pkg::*;

  typedef enum logic [1:0] {
    LD_IDLE    = 2'd0,
    LD_OPERAND = 2'd1,
    LD_PTR_LO  = 2'd2,
    LD_PTR_HI  = 2'd3
  } load_phase_t;

  logic [7:0]  acc, ix, iy;
  logic        zf, nf;
  load_phase_t ph;
  logic [7:0]  pend_op, ptr, ptr_lo;
  logic        crossed;

  res_t expected_results[$];
  int   mismatches = 0;
  int   outstanding = 0;

  assign fail_count = mismatches;
  assign pending = outstanding;

  function automatic op_info_t decode_load(input logic [7:0] op);
    op_info_t d;
    d.ok = 1'b1;
    d.mode = MODE_IMM;
    d.dest = SEL_A;
    d.idx = SEL_A;
    case (op)
      OP_LDA_IMM:  d.mode = MODE_IMM;
      OP_LDA_ZP:   d.mode = MODE_ZP;
      OP_LDA_ZPX:  begin d.mode = MODE_ZPI;  d.idx = SEL_X; end
      OP_LDA_ABS:  d.mode = MODE_ABS;
      OP_LDA_ABSX: begin d.mode = MODE_ABSI; d.idx = SEL_X; end
      OP_LDA_ABSY: begin d.mode = MODE_ABSI; d.idx = SEL_Y; end
      OP_LDA_INDX: begin d.mode = MODE_INX;  d.idx = SEL_X; end
      OP_LDA_INDY: begin d.mode = MODE_INY;  d.idx = SEL_Y; end
      OP_LDX_IMM:  begin d.mode = MODE_IMM;  d.dest = SEL_X; end
      OP_LDX_ZP:   begin d.mode = MODE_ZP;   d.dest = SEL_X; end
      OP_LDX_ZPY:  begin d.mode = MODE_ZPI;  d.dest = SEL_X; d.idx = SEL_Y; end
      OP_LDX_ABS:  begin d.mode = MODE_ABS;  d.dest = SEL_X; end
      OP_LDX_ABSY: begin d.mode = MODE_ABSI; d.dest = SEL_X; d.idx = SEL_Y; end
      OP_LDY_IMM:  begin d.mode = MODE_IMM;  d.dest = SEL_Y; end
      OP_LDY_ZP:   begin d.mode = MODE_ZP;   d.dest = SEL_Y; end
      OP_LDY_ZPX:  begin d.mode = MODE_ZPI;  d.dest = SEL_Y; d.idx = SEL_X; end
      OP_LDY_ABS:  begin d.mode = MODE_ABS;  d.dest = SEL_Y; end
      OP_LDY_ABSX: begin d.mode = MODE_ABSI; d.dest = SEL_Y; d.idx = SEL_X; end
      default:     d.ok = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] index_of(input sel_t s);
    if (s == SEL_X) return ix;
    if (s == SEL_Y) return iy;
    return 8'h00;
  endfunction

  function automatic logic [2:0] cycles_for(input mode_t m);
    case (m)
      MODE_IMM:  return 3'd2;
      MODE_ZP:   return 3'd3;
      MODE_INX:  return 3'd6;
      MODE_INY:  return 3'd5;
      default:   return 3'd4;
    endcase
  endfunction

  task automatic write_register(input sel_t dest, input logic [7:0] v);
    if (dest == SEL_A) acc = v;
    else if (dest == SEL_X) ix = v;
    else iy = v;
    zf = (v == 8'h00);
    nf = v[7];
  endtask

  task automatic predict_load_step(input logic kind, input logic [7:0] op,
                                   input logic [15:0] opnd, input logic [7:0] data,
                                   output res_t r);
    op_info_t    d;
    logic [1:0]  rk;
    logic [15:0] addr;
    logic [15:0] base;
    logic [2:0]  cyc;
    rk = RK_SEQ;
    addr = 16'h0000;
    cyc = 3'd0;
    if (kind == ITEM_INSTR) begin
      d = decode_load(op);
      if (ph != LD_IDLE) begin
        rk = RK_SEQ;
      end else if (!d.ok) begin
        rk = RK_UNSUP;
      end else begin
        pend_op = op;
        crossed = 1'b0;
        rk = RK_READ;
        case (d.mode)
          MODE_IMM: begin
            write_register(d.dest, opnd[7:0]);
            rk = RK_DONE;
            cyc = cycles_for(MODE_IMM);
          end
          MODE_ZP:  addr = {8'h00, opnd[7:0]};
          MODE_ZPI: addr = {8'h00, opnd[7:0] + index_of(d.idx)};
          MODE_ABS: addr = opnd;
          MODE_ABSI: begin
            addr = opnd + {8'h00, index_of(d.idx)};
            crossed = (addr[15:8] != opnd[15:8]);
          end
          default: begin
            ptr = (d.mode == MODE_INX) ? opnd[7:0] + ix : opnd[7:0];
            addr = {8'h00, ptr};
          end
        endcase
        if (rk == RK_READ) ph = (d.mode == MODE_INX || d.mode == MODE_INY) ?
                                LD_PTR_LO : LD_OPERAND;
      end
    end else begin
      d = decode_load(pend_op);
      if (ph == LD_IDLE || !d.ok) begin
        rk = RK_SEQ;
      end else if (ph == LD_PTR_LO) begin
        ptr_lo = data;
        ph = LD_PTR_HI;
        rk = RK_READ;
        addr = {8'h00, ptr + 8'd1};
      end else if (ph == LD_PTR_HI) begin
        base = {data, ptr_lo};
        if (d.mode == MODE_INY) begin
          addr = base + {8'h00, iy};
          crossed = (addr[15:8] != base[15:8]);
        end else begin
          addr = base;
          crossed = 1'b0;
        end
        ph = LD_OPERAND;
        rk = RK_READ;
      end else begin
        write_register(d.dest, data);
        ph = LD_IDLE;
        rk = RK_DONE;
        cyc = cycles_for(d.mode);
        if ((d.mode == MODE_ABSI || d.mode == MODE_INY) && crossed) cyc = cyc + 3'd1;
      end
    end
    r = {rk, addr, acc, ix, iy, zf, nf, cyc};
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    res_t nxt;
    if (rst) begin
      acc = 8'h00;
      ix = 8'h00;
      iy = 8'h00;
      zf = 1'b0;
      nf = 1'b0;
      ph = LD_IDLE;
      pend_op = 8'h00;
      ptr = 8'h00;
      ptr_lo = 8'h00;
      crossed = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {result_kind, read_address, reg_a, reg_x, reg_y,
               flag_zero, flag_negative, cycles_used};
        if (expected_results.size() == 0) begin
          $error("result item with no prediction pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("read_address", want.addr, got.addr);
          check_field("reg_a", want.a, got.a);
          check_field("reg_x", want.x, got.x);
          check_field("reg_y", want.y, got.y);
          check_field("flag_zero", want.z, got.z);
          check_field("flag_negative", want.n, got.n);
          check_field("cycles_used", want.cyc, got.cyc);
        end
      end
      if (in_valid && !in_stall) begin
        predict_load_step(item_kind, opcode, operand, read_data, nxt);
        expected_results.push_back(nxt);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* bench/cpu_load_register_unit_tb.sv */
`timescale 1ns / 1ps

module cpu_load_register_unit_tb;
  import clru_bench_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        item_kind;
  logic [7:0]  opcode;
  logic [15:0] operand;
  logic [7:0]  read_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  result_kind;
  logic [15:0] read_address;
  logic [7:0]  reg_a;
  logic [7:0]  reg_x;
  logic [7:0]  reg_y;
  logic        flag_zero;
  logic        flag_negative;
  logic [2:0]  cycles_used;
  int          fail_count;
  int          pending;

  logic in_taken = 1'b0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   counted = 0;
  int   send_quiet = 0;

  cpu_load_register_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .item_kind(item_kind), .opcode(opcode), .operand(operand), .read_data(read_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .read_address(read_address),
    .reg_a(reg_a), .reg_x(reg_x), .reg_y(reg_y),
    .flag_zero(flag_zero), .flag_negative(flag_negative), .cycles_used(cycles_used)
  );

  cpu_load_register_unit_checker CHK (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .item_kind(item_kind), .opcode(opcode), .operand(operand), .read_data(read_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .read_address(read_address),
    .reg_a(reg_a), .reg_x(reg_x), .reg_y(reg_y),
    .flag_zero(flag_zero), .flag_negative(flag_negative), .cycles_used(cycles_used),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  function automatic int reads_for(input logic [7:0] op);
    case (op)
      OP_LDA_INDX, OP_LDA_INDY: return 3;
      OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_ABS, OP_LDA_ABSX, OP_LDA_ABSY,
      OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABSY,
      OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABSX: return 1;
      default: return 0;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance, sometimes after a random idle gap.
  task automatic send_item(input logic kind, input logic [7:0] op,
                           input logic [15:0] opnd, input logic [7:0] data);
    int r;
    in_valid <= 1'b1;
    item_kind <= kind;
    opcode <= op;
    operand <= opnd;
    read_data <= data;
    do @(negedge clk); while (!in_taken);
    if (!calm) begin
      if (send_quiet > 0) begin
        send_quiet--;
      end else begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          send_quiet = $urandom_range(20, 60);
        end else if (r < 4) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 9)) @(negedge clk);
        end
      end
    end
  endtask

  // Send an instruction and the data items it asks for; optionally slip an
  // instruction in while the load is still pending.
  task automatic run_load(input logic [7:0] op, input bit intrude);
    int n;
    int spot;
    logic [15:0] opnd;
    logic [7:0]  data;
    n = reads_for(op);
    spot = (intrude && n > 0) ? $urandom_range(0, n - 1) : -1;
    case ($urandom_range(0, 7))
      0:       opnd = 16'hFFFF;
      1:       opnd = 16'h0000;
      2:       opnd = {8'($urandom), 8'hFF};
      3:       opnd = {8'($urandom), 8'($urandom_range(200, 255))};
      default: opnd = 16'($urandom);
    endcase
    send_item(ITEM_INSTR, op, opnd, 8'($urandom));
    counted++;
    for (int i = 0; i < n; i++) begin
      if (i == spot) begin
        send_item(ITEM_INSTR, 8'($urandom), 16'($urandom), 8'($urandom));
        counted++;
      end
      case ($urandom_range(0, 9))
        0:       data = 8'h00;
        1:       data = 8'h80;
        2:       data = 8'hFF;
        3:       data = 8'h7F;
        default: data = 8'($urandom);
      endcase
      send_item(ITEM_DATA, 8'($urandom), 16'($urandom), data);
      counted++;
    end
  endtask

  initial begin : receiver
    int r;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (120) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          repeat ($urandom_range(20, 60)) @(negedge clk);
        end else if (r < 4) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 9)) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    item_kind = ITEM_INSTR;
    opcode = 8'h00;
    operand = 16'h0000;
    read_data = 8'h00;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(ITEM_INSTR, OP_LDX_IMM, 16'h00FF, 8'h00);
    send_item(ITEM_INSTR, OP_LDY_IMM, 16'hFF80, 8'h00);
    send_item(ITEM_INSTR, OP_LDA_IMM, 16'hFF00, 8'hFF);
    // zero page indexed wraps within page zero
    send_item(ITEM_INSTR, OP_LDA_ZPX, 16'hAB80, 8'h00);
    send_item(ITEM_DATA, 8'hFF, 16'hFFFF, 8'h7F);
    send_item(ITEM_INSTR, OP_LDX_ZPY, 16'h00FF, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h01);
    // absolute indexed across a page, then across the top of memory
    send_item(ITEM_INSTR, OP_LDY_ABSX, 16'h12FF, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'hFF);
    send_item(ITEM_INSTR, OP_LDA_ABSY, 16'hFFFF, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h80);
    // pointer at the end of page zero wraps for its high byte
    send_item(ITEM_INSTR, OP_LDA_INDX, 16'h00FE, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'hF0);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h12);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h55);
    send_item(ITEM_INSTR, OP_LDA_INDY, 16'h0040, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h80);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h20);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h00);
    send_item(ITEM_INSTR, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(ITEM_INSTR, 8'h00, 16'h0000, 8'h00);
    // data while idle, then an instruction while a load is pending
    send_item(ITEM_DATA, 8'hA9, 16'h1234, 8'h99);
    send_item(ITEM_INSTR, OP_LDY_ZP, 16'h0000, 8'h00);
    send_item(ITEM_INSTR, OP_LDA_IMM, 16'h0001, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h80);
    send_item(ITEM_INSTR, OP_LDX_ABS, 16'hFFFF, 8'h00);
    send_item(ITEM_DATA, 8'h00, 16'h0000, 8'h00);

    counted = 0;
    while (counted < 1350) begin
      if (counted >= 1200) calm = 1'b1;
      if (counted >= 400) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 80) run_load(load_opcode($urandom_range(0, 17)), 1'b0);
      else if (r < 88) run_load(8'($urandom), 1'b0);
      else if (r < 94) run_load(load_opcode($urandom_range(0, 17)), 1'b1);
      else begin
        send_item(ITEM_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
        counted++;
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
